FILE: design/ttw_pkg.sv
// shared types, constants and the sequencer microprogram of the text terminal writer
package ttw_pkg;

  // default screen store geometry
  localparam int unsigned MaxColsDef = 128;
  localparam int unsigned MaxRowsDef = 64;

  // operation codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_SET   = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_COLUMNS     = 2'd0;
  localparam logic [1:0] CFG_ROWS        = 2'd1;
  localparam logic [1:0] CFG_TEXT_ATTR   = 2'd2;
  localparam logic [1:0] CFG_SHOW_CURSOR = 2'd3;

  // register reset values
  localparam logic [7:0] COLUMNS_RST     = 8'd80;
  localparam logic [6:0] ROWS_RST        = 7'd30;
  localparam logic [7:0] TEXT_ATTR_RST   = 8'd15;
  localparam logic       SHOW_CURSOR_RST = 1'b1;

  localparam logic [7:0]  LINE_FEED     = 8'd10;
  localparam logic [7:0]  LOW_NIBBLE    = 8'h0f;
  localparam logic [15:0] HIDDEN_CURSOR = 16'hffff;
  localparam int unsigned ROW_SHIFT     = 8;

  // one input transaction
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] ch;
    logic [6:0] col;
    logic [5:0] row;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic        status;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [6:0]  cursor_col;
    logic [5:0]  cursor_row;
    logic [15:0] hw_cursor;
    logic        scrolled;
  } result_t;

  // microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE   = 4'd0;
  localparam step_t ST_P_MUL  = 4'd1;
  localparam step_t ST_P_WR   = 4'd2;
  localparam step_t ST_P_CHK  = 4'd3;
  localparam step_t ST_S_TEST = 4'd4;
  localparam step_t ST_S_RD   = 4'd5;
  localparam step_t ST_S_WR   = 4'd6;
  localparam step_t ST_S_FSET = 4'd7;
  localparam step_t ST_S_FILL = 4'd8;
  localparam step_t ST_EMIT   = 4'd9;
  localparam step_t ST_C_MUL  = 4'd10;
  localparam step_t ST_C_FILL = 4'd11;
  localparam step_t ST_C_HOME = 4'd12;
  localparam step_t ST_SET    = 4'd13;
  localparam step_t ST_R_MUL  = 4'd14;
  localparam step_t ST_R_RD   = 4'd15;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_CUR, MUL_IN, MUL_LAST, MUL_ALL
  } mul_op_e;

  typedef enum logic [2:0] {
    MEM_NONE, MEM_PUT, MEM_RD_CELL, MEM_RD_COPY, MEM_WR_COPY, MEM_WR_CLEAR, MEM_WR_BOTTOM
  } mem_op_e;

  typedef enum logic [1:0] {
    CNT_HOLD, CNT_CLR, CNT_INC, CNT_LOAD
  } cnt_op_e;

  typedef enum logic [1:0] {
    CUR_HOLD, CUR_ADV, CUR_SET, CUR_HOME
  } cur_op_e;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_GOTO, JMP_DISPATCH, JMP_NO_SCROLL, JMP_CNT_DONE, JMP_LOOP
  } jmp_e;

  // one control word
  typedef struct packed {
    mul_op_e mul;
    mem_op_e mem;
    cnt_op_e cnt;
    cur_op_e cur;
    jmp_e    jmp;
    step_t   target;
    logic    emit;
  } ctrl_t;

  // microprogram rom
  function automatic ctrl_t ucode(step_t s);
    ctrl_t c;
    c.mul    = MUL_NONE;
    c.mem    = MEM_NONE;
    c.cnt    = CNT_HOLD;
    c.cur    = CUR_HOLD;
    c.jmp    = JMP_NEXT;
    c.target = ST_IDLE;
    c.emit   = 1'b0;
    unique case (s)
      ST_IDLE: begin
        c.jmp = JMP_DISPATCH;
      end
      ST_P_MUL: begin
        c.mul = MUL_CUR;
      end
      ST_P_WR: begin
        c.mem = MEM_PUT;
        c.cur = CUR_ADV;
        c.mul = MUL_LAST;
        c.cnt = CNT_CLR;
      end
      ST_P_CHK: begin
        c.jmp    = JMP_NO_SCROLL;
        c.target = ST_EMIT;
      end
      ST_S_TEST: begin
        c.jmp    = JMP_CNT_DONE;
        c.target = ST_S_FSET;
      end
      ST_S_RD: begin
        c.mem = MEM_RD_COPY;
      end
      ST_S_WR: begin
        c.mem    = MEM_WR_COPY;
        c.cnt    = CNT_INC;
        c.jmp    = JMP_GOTO;
        c.target = ST_S_TEST;
      end
      ST_S_FSET: begin
        c.cnt = CNT_LOAD;
        c.mul = MUL_ALL;
      end
      ST_S_FILL: begin
        c.mem    = MEM_WR_BOTTOM;
        c.cnt    = CNT_INC;
        c.jmp    = JMP_LOOP;
        c.target = ST_S_FILL;
      end
      ST_EMIT: begin
        c.emit   = 1'b1;
        c.jmp    = JMP_GOTO;
        c.target = ST_IDLE;
      end
      ST_C_MUL: begin
        c.mul = MUL_ALL;
        c.cnt = CNT_CLR;
      end
      ST_C_FILL: begin
        c.mem    = MEM_WR_CLEAR;
        c.cnt    = CNT_INC;
        c.jmp    = JMP_LOOP;
        c.target = ST_C_FILL;
      end
      ST_C_HOME: begin
        c.cur    = CUR_HOME;
        c.jmp    = JMP_GOTO;
        c.target = ST_EMIT;
      end
      ST_SET: begin
        c.cur    = CUR_SET;
        c.jmp    = JMP_GOTO;
        c.target = ST_EMIT;
      end
      ST_R_MUL: begin
        c.mul = MUL_IN;
      end
      default: begin
        c.mem    = MEM_RD_CELL;
        c.jmp    = JMP_GOTO;
        c.target = ST_EMIT;
      end
    endcase
    return c;
  endfunction

endpackage

FILE: design/text_terminal_writer_core.sv
// text terminal writer: microcoded sequencer over a single-port-write cell store
// put: multiply, write, scroll check, emit; set: set, emit; read: multiply, read, emit
// clear fills every screen cell, then homes the cursor; a scrolling put adds the row copy
// one transaction at a time, set by the one write and one read port of the cell store
// reset clears cursor and sequencer and reloads the configuration registers; the cell store is not cleared (no sweep)
// results are strobed for one cycle on done_o and cannot be held off by the receiver
module text_terminal_writer_core #(
  parameter int unsigned MAX_COLS = ttw_pkg::MaxColsDef,
  parameter int unsigned MAX_ROWS = ttw_pkg::MaxRowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command transaction
  input  logic             start,
  output logic             busy,
  input  ttw_pkg::cmd_t    cmd_i,
  // result transaction
  output logic             done_o,
  output ttw_pkg::result_t result_o,
  // configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [7:0]       cfg_data_i
);

  // geometry derived widths
  localparam int unsigned Depth = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned NcW   = $clog2(MAX_COLS + 1);
  localparam int unsigned NrW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned CcW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned CrW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // configuration registers
  logic [7:0] columns_q;
  logic [6:0] rows_q;
  logic [7:0] text_attr_q;
  logic       show_cursor_q;

  // sequencer and datapath state
  ttw_pkg::step_t   step_q, step_d;
  ttw_pkg::ctrl_t   uc;
  ttw_pkg::cmd_t    cmd_q;
  logic [CcW-1:0]   cur_col_q;
  logic [CrW-1:0]   cur_row_q;
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  prod_q, prod_d;
  logic             status_q, scroll_q, rd_ok_q;
  logic [15:0]      rdata_q;
  logic             done_q;
  ttw_pkg::result_t result_q, result_d;

  // cell store
  logic [15:0]      cell_mem_q [Depth];
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [15:0]      mem_wdata;

  // effective screen size and derived values
  logic [NcW-1:0]   nc;
  logic [NrW-1:0]   nr;
  logic [NrW-1:0]   mul_a;
  logic             accept;
  logic             cmd_in_range;
  logic             cur_on_screen;
  logic [CcW:0]     col_inc;
  logic [CrW:0]     row_ext;
  logic [CcW-1:0]   adv_col;
  logic [CrW-1:0]   adv_row;
  logic             adv_scroll;
  logic             put_char;
  logic [15:0]      hw_cursor;

  assign uc          = ttw_pkg::ucode(step_q);
  assign busy        = (step_q != ttw_pkg::ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = !busy;
  assign done_o      = done_q;
  assign result_o    = result_q;

  // a size of zero acts as one, a size above the store acts as the store limit
  always_comb begin
    if (columns_q == '0) begin
      nc = NcW'(1);
    end else if (32'(columns_q) > MAX_COLS) begin
      nc = NcW'(MAX_COLS);
    end else begin
      nc = NcW'(columns_q);
    end
    if (rows_q == '0) begin
      nr = NrW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      nr = NrW'(MAX_ROWS);
    end else begin
      nr = NrW'(rows_q);
    end
  end

  assign cmd_in_range  = (32'(cmd_q.col) < 32'(nc)) && (32'(cmd_q.row) < 32'(nr));
  assign cur_on_screen = (32'(cur_col_q) < 32'(nc)) && (32'(cur_row_q) < 32'(nr));
  assign put_char      = (cmd_q.ch != 8'd0) && (cmd_q.ch != ttw_pkg::LINE_FEED);

  // cursor advance for a put: wrap at the column limit, scroll past the last row
  always_comb begin
    col_inc = (CcW+1)'(cur_col_q) + 1'b1;
    row_ext = (CrW+1)'(cur_row_q);
    adv_col = cur_col_q;
    if (cmd_q.ch == ttw_pkg::LINE_FEED) begin
      adv_col = '0;
      row_ext = (CrW+1)'(cur_row_q) + 1'b1;
    end else if (32'(col_inc) >= 32'(nc)) begin
      adv_col = '0;
      row_ext = (CrW+1)'(cur_row_q) + 1'b1;
    end else begin
      adv_col = CcW'(col_inc);
    end
    if (32'(row_ext) >= 32'(nr)) begin
      adv_row    = CrW'(nr - 1'b1);
      adv_scroll = 1'b1;
    end else begin
      adv_row    = CrW'(row_ext);
      adv_scroll = 1'b0;
    end
  end

  // step counter with conditional jumps
  always_comb begin
    step_d = ttw_pkg::step_t'(step_q + 1'b1);
    unique case (uc.jmp)
      ttw_pkg::JMP_NEXT: begin
        step_d = ttw_pkg::step_t'(step_q + 1'b1);
      end
      ttw_pkg::JMP_GOTO: begin
        step_d = uc.target;
      end
      ttw_pkg::JMP_DISPATCH: begin
        if (accept) begin
          unique case (cmd_i.op)
            ttw_pkg::OP_PUT:   step_d = ttw_pkg::ST_P_MUL;
            ttw_pkg::OP_CLEAR: step_d = ttw_pkg::ST_C_MUL;
            ttw_pkg::OP_SET:   step_d = ttw_pkg::ST_SET;
            default:           step_d = ttw_pkg::ST_R_MUL;
          endcase
        end else begin
          step_d = ttw_pkg::ST_IDLE;
        end
      end
      ttw_pkg::JMP_NO_SCROLL: begin
        if (!scroll_q) begin
          step_d = uc.target;
        end
      end
      ttw_pkg::JMP_CNT_DONE: begin
        if (cnt_q >= prod_q) begin
          step_d = uc.target;
        end
      end
      ttw_pkg::JMP_LOOP: begin
        if (CntW'(cnt_q + 1'b1) < prod_q) begin
          step_d = uc.target;
        end
      end
      default: begin
        step_d = ttw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ttw_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  // shared row multiplier, registered before any use
  always_comb begin
    unique case (uc.mul)
      ttw_pkg::MUL_CUR:  mul_a = NrW'(cur_row_q);
      ttw_pkg::MUL_IN:   mul_a = NrW'(cmd_q.row);
      ttw_pkg::MUL_LAST: mul_a = NrW'(nr - 1'b1);
      ttw_pkg::MUL_ALL:  mul_a = nr;
      default:           mul_a = '0;
    endcase
    prod_d = CntW'(CntW'(mul_a) * CntW'(nc));
  end

  always_ff @(posedge clk_i) begin
    if (uc.mul != ttw_pkg::MUL_NONE) begin
      prod_q <= prod_d;
    end
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  // cell counter for sweeps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (uc.cnt)
        ttw_pkg::CNT_CLR:  cnt_q <= '0;
        ttw_pkg::CNT_INC:  cnt_q <= CntW'(cnt_q + 1'b1);
        ttw_pkg::CNT_LOAD: cnt_q <= prod_q;
        default:           cnt_q <= cnt_q;
      endcase
    end
  end

  // cursor and per-transaction flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      status_q  <= 1'b0;
      scroll_q  <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      if (accept) begin
        status_q <= 1'b0;
        scroll_q <= 1'b0;
        rd_ok_q  <= 1'b0;
      end
      case (uc.cur)
        ttw_pkg::CUR_ADV: begin
          // a null character leaves everything as it is
          if (cmd_q.ch != 8'd0) begin
            cur_col_q <= adv_col;
            cur_row_q <= adv_row;
            scroll_q  <= adv_scroll;
          end
        end
        ttw_pkg::CUR_SET: begin
          if (cmd_in_range) begin
            cur_col_q <= CcW'(cmd_q.col);
            cur_row_q <= CrW'(cmd_q.row);
          end else begin
            status_q <= 1'b1;
          end
        end
        ttw_pkg::CUR_HOME: begin
          cur_col_q <= '0;
          cur_row_q <= '0;
        end
        default: begin
          cur_col_q <= cur_col_q;
        end
      endcase
      if (uc.mem == ttw_pkg::MEM_RD_CELL) begin
        if (cmd_in_range) begin
          rd_ok_q <= 1'b1;
        end else begin
          status_q <= 1'b1;
        end
      end
    end
  end

  // cell store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(cnt_q);
    mem_raddr = AW'(cnt_q + CntW'(nc));
    mem_wdata = {text_attr_q, 8'd0};
    case (uc.mem)
      ttw_pkg::MEM_PUT: begin
        // off-screen cursor after a size change writes nothing
        mem_we    = put_char && cur_on_screen;
        mem_waddr = AW'(prod_q + CntW'(cur_col_q));
        mem_wdata = {text_attr_q, cmd_q.ch};
      end
      ttw_pkg::MEM_RD_CELL: begin
        mem_re    = cmd_in_range;
        mem_raddr = AW'(prod_q + CntW'(cmd_q.col));
      end
      ttw_pkg::MEM_RD_COPY: begin
        mem_re = 1'b1;
      end
      ttw_pkg::MEM_WR_COPY: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      ttw_pkg::MEM_WR_CLEAR: begin
        mem_we = 1'b1;
      end
      ttw_pkg::MEM_WR_BOTTOM: begin
        mem_we    = 1'b1;
        mem_wdata = {text_attr_q & ttw_pkg::LOW_NIBBLE, 8'd0};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= cell_mem_q[mem_raddr];
    end
  end

  // result register, loaded in the emit step from the state after the step
  always_comb begin
    if (show_cursor_q) begin
      hw_cursor = (16'(cur_row_q) << ttw_pkg::ROW_SHIFT) | 16'(cur_col_q);
    end else begin
      hw_cursor = ttw_pkg::HIDDEN_CURSOR;
    end
    result_d.status     = status_q;
    result_d.cell_char  = rd_ok_q ? rdata_q[7:0] : 8'd0;
    result_d.cell_attr  = rd_ok_q ? rdata_q[15:8] : 8'd0;
    result_d.cursor_col = 7'(cur_col_q);
    result_d.cursor_row = 6'(cur_row_q);
    result_d.hw_cursor  = hw_cursor;
    result_d.scrolled   = scroll_q;
  end

  always_ff @(posedge clk_i) begin
    if (uc.emit) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= uc.emit;
    end
  end

  // configuration writes, only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q     <= ttw_pkg::COLUMNS_RST;
      rows_q        <= ttw_pkg::ROWS_RST;
      text_attr_q   <= ttw_pkg::TEXT_ATTR_RST;
      show_cursor_q <= ttw_pkg::SHOW_CURSOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ttw_pkg::CFG_COLUMNS:   columns_q     <= cfg_data_i;
        ttw_pkg::CFG_ROWS:      rows_q        <= cfg_data_i[6:0];
        ttw_pkg::CFG_TEXT_ATTR: text_attr_q   <= cfg_data_i;
        default:                show_cursor_q <= cfg_data_i[0];
      endcase
    end
  end

endmodule

FILE: tb/text_terminal_writer_core_tb.sv
// self-checking testbench for the text terminal writer core
module text_terminal_writer_core_tb;

  localparam int Cols  = int'(ttw_pkg::MaxColsDef);
  localparam int Rows  = int'(ttw_pkg::MaxRowsDef);
  localparam int Cells = Cols * Rows;

  // one screen setting and how much traffic runs under it
  typedef struct {
    int cols;
    int rows;
    int attr;
    int show;
    bit clear_first;
    int count;
  } phase_t;

  // one directed transaction, with a hand-written answer where it is obvious
  typedef struct {
    ttw_pkg::cmd_t    cmd;
    bit               typed;
    ttw_pkg::result_t answer;
  } directed_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  ttw_pkg::cmd_t    cmd_i       = '0;
  logic             cfg_valid_i = 1'b0;
  logic [1:0]       cfg_index_i = ttw_pkg::CFG_COLUMNS;
  logic [7:0]       cfg_data_i  = 8'h00;
  logic             busy;
  logic             done_o;
  logic             cfg_ready_o;
  ttw_pkg::result_t result_o;

  text_terminal_writer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow of the screen: cell contents plus a flag for cells written since reset
  logic [15:0] text_ram [Cells];
  bit          text_ram_valid [Cells];
  int          cur_x, cur_y;
  int          columns_reg, rows_reg, attr_reg, show_reg;

  ttw_pkg::result_t pending_reports[$];
  directed_row_t    directed[$];
  phase_t           plan[11];
  int               mismatches = 0;
  int               burst_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the core hangs
  initial begin
    #1_000_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // size registers saturate: zero acts as one, anything above the store acts as the maximum
  function automatic int clamp_size(int v, int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  // screen behaviour for one command transaction; updates the shadow state
  function automatic ttw_pkg::result_t terminal_step(ttw_pkg::cmd_t c);
    int               nc, nr, i, x, y;
    ttw_pkg::result_t r;
    r  = '0;
    nc = clamp_size(columns_reg, Cols);
    nr = clamp_size(rows_reg, Rows);
    case (c.op)
      ttw_pkg::OP_PUT: begin
        // a zero character is dropped without any side effect
        if (c.ch != 8'h00) begin
          if (c.ch != ttw_pkg::LINE_FEED) begin
            // a cursor left off screen by a resize writes nothing but still advances
            if (cur_x < nc && cur_y < nr) begin
              text_ram[cur_y * nc + cur_x]       = {attr_reg[7:0], c.ch};
              text_ram_valid[cur_y * nc + cur_x] = 1'b1;
            end
            cur_x++;
            if (cur_x >= nc) begin
              cur_x = 0;
              cur_y++;
            end
          end else begin
            cur_x = 0;
            cur_y++;
          end
          // past the last row: shift every row up once and blank the bottom row
          if (cur_y >= nr) begin
            cur_y = nr - 1;
            for (y = 0; y + 1 < nr; y++) begin
              for (x = 0; x < nc; x++) begin
                text_ram[y * nc + x]       = text_ram[(y + 1) * nc + x];
                text_ram_valid[y * nc + x] = text_ram_valid[(y + 1) * nc + x];
              end
            end
            for (x = 0; x < nc; x++) begin
              text_ram[(nr - 1) * nc + x]       = {attr_reg[7:0] & ttw_pkg::LOW_NIBBLE, 8'h00};
              text_ram_valid[(nr - 1) * nc + x] = 1'b1;
            end
            r.scrolled = 1'b1;
          end
        end
      end
      ttw_pkg::OP_CLEAR: begin
        for (i = 0; i < nc * nr; i++) begin
          text_ram[i]       = {attr_reg[7:0], 8'h00};
          text_ram_valid[i] = 1'b1;
        end
        cur_x = 0;
        cur_y = 0;
      end
      ttw_pkg::OP_SET: begin
        if (c.col < nc && c.row < nr) begin
          cur_x = int'(c.col);
          cur_y = int'(c.row);
        end else begin
          r.status = 1'b1;
        end
      end
      default: begin
        if (c.col < nc && c.row < nr) begin
          {r.cell_attr, r.cell_char} = text_ram[c.row * nc + c.col];
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    r.cursor_col = cur_x[6:0];
    r.cursor_row = cur_y[5:0];
    if (show_reg != 0) begin
      r.hw_cursor = 16'((cur_y << ttw_pkg::ROW_SHIFT) | cur_x);
    end else begin
      r.hw_cursor = ttw_pkg::HIDDEN_CURSOR;
    end
    return r;
  endfunction

  function automatic ttw_pkg::cmd_t mk(logic [1:0] op, logic [7:0] ch, logic [6:0] col,
                                       logic [5:0] row);
    ttw_pkg::cmd_t c;
    c.op  = op;
    c.ch  = ch;
    c.col = col;
    c.row = row;
    return c;
  endfunction

  function automatic ttw_pkg::result_t rep(logic st, logic [7:0] chr, logic [7:0] at,
                                           logic [6:0] cx, logic [5:0] cy, logic [15:0] hw,
                                           logic sc);
    ttw_pkg::result_t r;
    r.status     = st;
    r.cell_char  = chr;
    r.cell_attr  = at;
    r.cursor_col = cx;
    r.cursor_row = cy;
    r.hw_cursor  = hw;
    r.scrolled   = sc;
    return r;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // sender works in bursts; start stays high across back-to-back transactions
  task automatic issue(ttw_pkg::cmd_t c, bit typed = 1'b0, ttw_pkg::result_t answer = '0);
    int               gap;
    ttw_pkg::result_t pred;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    pred = terminal_step(c);
    pending_reports.push_back(typed ? answer : pred);
  endtask

  // drop start and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
  endtask

  // one register write; valid stays high for the caller to lower after the last one
  task automatic cfg_put(logic [1:0] idx, logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      ttw_pkg::CFG_COLUMNS:   columns_reg = int'(data);
      ttw_pkg::CFG_ROWS:      rows_reg    = int'(data & 8'h7f);
      ttw_pkg::CFG_TEXT_ATTR: attr_reg    = int'(data);
      default:                show_reg    = int'(data & 8'h01);
    endcase
  endtask

  task automatic run_phase(phase_t p);
    int            nc, nr, n, pick, sel;
    ttw_pkg::cmd_t c;
    drain();
    cfg_put(ttw_pkg::CFG_COLUMNS, 8'(p.cols));
    cfg_put(ttw_pkg::CFG_ROWS, 8'(p.rows));
    cfg_put(ttw_pkg::CFG_TEXT_ATTR, 8'(p.attr));
    cfg_put(ttw_pkg::CFG_SHOW_CURSOR, 8'(p.show));
    cfg_valid_i <= 1'b0;
    nc = clamp_size(columns_reg, Cols);
    nr = clamp_size(rows_reg, Rows);
    if (p.clear_first) begin
      issue(mk(ttw_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
               6'($urandom_range(0, 63))));
    end else begin
      // cursor is still where the larger screen left it, so the first of these lands off screen
      issue(mk(ttw_pkg::OP_PUT, 8'($urandom_range(11, 255)), 7'd0, 6'd0));
      issue(mk(ttw_pkg::OP_PUT, ttw_pkg::LINE_FEED, 7'd0, 6'd0));
      issue(mk(ttw_pkg::OP_PUT, 8'($urandom_range(1, 255)), 7'd0, 6'd0));
    end
    for (n = 0; n < p.count; n++) begin
      c.ch  = 8'($urandom_range(0, 255));
      c.col = 7'($urandom_range(0, 127));
      c.row = 6'($urandom_range(0, 63));
      pick  = $urandom_range(0, 99);
      if (pick < 55) begin
        // mostly text, with line feeds and the odd null mixed in
        c.op = ttw_pkg::OP_PUT;
        sel  = $urandom_range(0, 19);
        if (sel < 3) begin
          c.ch = ttw_pkg::LINE_FEED;
        end else if (sel == 3) begin
          c.ch = 8'h00;
        end
      end else if (pick < 94) begin
        c.op = (pick < 70) ? ttw_pkg::OP_SET : ttw_pkg::OP_READ;
        // most positions on screen, some anywhere in the field range
        if ($urandom_range(0, 4) != 0) begin
          c.col = 7'($urandom_range(0, nc - 1));
          c.row = 6'($urandom_range(0, nr - 1));
        end
        // never look at a cell that has not been written since reset
        if (c.op == ttw_pkg::OP_READ && c.col < nc && c.row < nr &&
            !text_ram_valid[c.row * nc + c.col]) begin
          c.op = ttw_pkg::OP_SET;
        end
      end else begin
        c.op = ttw_pkg::OP_CLEAR;
      end
      issue(c);
    end
    // force a scroll at this size, then park the cursor in the far corner
    issue(mk(ttw_pkg::OP_SET, 8'h00, 7'(nc - 1), 6'(nr - 1)));
    issue(mk(ttw_pkg::OP_PUT, 8'($urandom_range(1, 255)), 7'd0, 6'd0));
    issue(mk(ttw_pkg::OP_SET, 8'h00, 7'(nc - 1), 6'(nr - 1)));
  endtask

  // result checker: one strobe, one transaction, compared against the oldest expectation
  always @(posedge clk_i) begin : result_check
    ttw_pkg::result_t want;
    if (rst_ni && done_o) begin
      if (pending_reports.size() == 0) begin
        $error("result with no transaction outstanding");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 16'(want.status), 16'(result_o.status));
        check_field("cell_char", 16'(want.cell_char), 16'(result_o.cell_char));
        check_field("cell_attr", 16'(want.cell_attr), 16'(result_o.cell_attr));
        check_field("cursor_col", 16'(want.cursor_col), 16'(result_o.cursor_col));
        check_field("cursor_row", 16'(want.cursor_row), 16'(result_o.cursor_row));
        check_field("hw_cursor", want.hw_cursor, result_o.hw_cursor);
        check_field("scrolled", 16'(want.scrolled), 16'(result_o.scrolled));
      end
    end
  end

  initial begin : stimulus
    int i;
    columns_reg = int'(ttw_pkg::COLUMNS_RST);
    rows_reg    = int'(ttw_pkg::ROWS_RST);
    attr_reg    = int'(ttw_pkg::TEXT_ATTR_RST);
    show_reg    = int'(ttw_pkg::SHOW_CURSOR_RST);
    cur_x       = 0;
    cur_y       = 0;
    for (i = 0; i < Cells; i++) begin
      text_ram[i]       = '0;
      text_ram_valid[i] = 1'b0;
    end

    // directed part at the reset setting (80 x 30, attribute 0x0f, cursor shown)
    directed.push_back('{mk(ttw_pkg::OP_SET, 8'h00, 7'd5, 6'd3), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd5, 6'd3, 16'h0305, 1'b0)});
    // set cursor just past the right and the bottom edge
    directed.push_back('{mk(ttw_pkg::OP_SET, 8'h00, 7'd80, 6'd0), 1'b1,
                         rep(1'b1, 8'h00, 8'h00, 7'd5, 6'd3, 16'h0305, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_SET, 8'h00, 7'd0, 6'd30), 1'b1,
                         rep(1'b1, 8'h00, 8'h00, 7'd5, 6'd3, 16'h0305, 1'b0)});
    // read off screen at the field maxima
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd127, 6'd63), 1'b1,
                         rep(1'b1, 8'h00, 8'h00, 7'd5, 6'd3, 16'h0305, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_CLEAR, 8'hff, 7'd127, 6'd63), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd0, 6'd0, 16'h0000, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h0f, 7'd0, 6'd0, 16'h0000, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_PUT, 8'h41, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd1, 6'd0, 16'h0001, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h41, 8'h0f, 7'd1, 6'd0, 16'h0001, 1'b0)});
    // null character is ignored
    directed.push_back('{mk(ttw_pkg::OP_PUT, 8'h00, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd1, 6'd0, 16'h0001, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_PUT, 8'hff, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd2, 6'd0, 16'h0002, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_PUT, ttw_pkg::LINE_FEED, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd0, 6'd1, 16'h0100, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_SET, 8'h00, 7'd79, 6'd29), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd79, 6'd29, 16'h1d4f, 1'b0)});
    // character in the last cell wraps and scrolls
    directed.push_back('{mk(ttw_pkg::OP_PUT, 8'h42, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd0, 6'd29, 16'h1d00, 1'b1)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd79, 6'd28), 1'b1,
                         rep(1'b0, 8'h42, 8'h0f, 7'd0, 6'd29, 16'h1d00, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd29), 1'b1,
                         rep(1'b0, 8'h00, 8'h0f, 7'd0, 6'd29, 16'h1d00, 1'b0)});
    // line feed on the last row scrolls too
    directed.push_back('{mk(ttw_pkg::OP_PUT, ttw_pkg::LINE_FEED, 7'd0, 6'd0), 1'b1,
                         rep(1'b0, 8'h00, 8'h00, 7'd0, 6'd29, 16'h1d00, 1'b1)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd79, 6'd27), 1'b1,
                         rep(1'b0, 8'h42, 8'h0f, 7'd0, 6'd29, 16'h1d00, 1'b0)});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd1, 6'd27), 1'b0, '0});
    directed.push_back('{mk(ttw_pkg::OP_PUT, 8'h80, 7'h55, 6'h2a), 1'b0, '0});
    directed.push_back('{mk(ttw_pkg::OP_SET, 8'h7f, 7'd0, 6'd0), 1'b0, '0});
    directed.push_back('{mk(ttw_pkg::OP_READ, 8'h00, 7'd2, 6'd0), 1'b0, '0});

    // screen settings: extremes, saturating sizes, hidden cursor and resize without clear
    plan = '{
      '{128,  64, 'h00, 1, 1'b1,  30},
      '{  5,   3, 'ha5, 1, 1'b0, 100},
      '{  0,   0, 'hff, 0, 1'b1,  40},
      '{ 16,   8, 'h3c, 1, 1'b1, 200},
      '{255, 127, 'h5a, 1, 1'b1,  30},
      '{  1,  64, 'h0f, 1, 1'b0,  80},
      '{128,   1, 'h81, 0, 1'b1,  80},
      '{  7,   5, 'hf0, 1, 1'b0, 200},
      '{ 12,   6, 'h07, 1, 1'b1, 200},
      '{  3,   2, 'hc3, 0, 1'b1, 150},
      '{ 80,  30, 'h0f, 1, 1'b1, 100}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) issue(directed[k].cmd, directed[k].typed, directed[k].answer);
    foreach (plan[k]) run_phase(plan[k]);

    drain();
    // allow for a stray late strobe before the verdict
    repeat (32) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: text_terminal_writer_core.f
design/ttw_pkg.sv
design/text_terminal_writer_core.sv
tb/text_terminal_writer_core_tb.sv
